// ----- hw/rtl/slt_pkg.sv -----
// Shared types and constants for the sequential list table.
// Entry layout, operation codes, ring control struct and stream widths.
// No dependencies.
package slt_pkg;

    localparam int CAPACITY = 128;
    localparam int POS_W    = 8;
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 88;

    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_AT   = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_SORT = 3'd2;
    localparam logic [OP_W-1:0] OP_LIN_FIND = 3'd3;
    localparam logic [OP_W-1:0] OP_BIN_FIND = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_AT   = 3'd5;
    localparam logic [OP_W-1:0] OP_REM_KEY  = 3'd6;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [DATA_W-1:0]       payload;
    } entry_t;

    typedef struct packed {
        logic fwd;
        logic bwd;
    } ring_ctl_t;

endpackage

// ----- hw/rtl/slt_cell.sv -----
// One storage cell of the entry ring.
// Loads from its forward or backward neighbor; uses slt_pkg.
module slt_cell
(
    input  logic               clk,
    input  slt_pkg::ring_ctl_t ctl,
    input  slt_pkg::entry_t    next_in,
    input  slt_pkg::entry_t    prev_in,
    output slt_pkg::entry_t    entry
);

    slt_pkg::entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.fwd)
        begin
            entry_reg <= next_in;
        end
        else if (ctl.bwd)
        begin
            entry_reg <= prev_in;
        end
    end

    assign entry = entry_reg;

endmodule

// ----- hw/rtl/slt_ctrl.sv -----
// Sequencer at the head of the entry ring: streams entries through for
// insert, find and remove, steers the ring for binary search; uses slt_pkg.
module slt_ctrl
#(
    parameter int CAPACITY = slt_pkg::CAPACITY
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [slt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [slt_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [slt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tuser,
    input  slt_pkg::entry_t                 head,
    input  slt_pkg::entry_t                 second,
    output slt_pkg::entry_t                 emit,
    output slt_pkg::ring_ctl_t              ring_ctl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_STREAM = 3'd1;
    localparam logic [2:0] S_BS     = 3'd2;
    localparam logic [2:0] S_ALIGN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam logic [7:0] CAP_W = 8'(CAPACITY);

    logic [2:0]                 state_reg, state_next;
    logic [slt_pkg::OP_W-1:0]   op_reg, op_next;
    logic [7:0]                 pos_reg, pos_next;
    logic signed [31:0]         key_reg, key_next;
    logic [31:0]                pay_reg, pay_next;
    logic [7:0]                 count_reg, count_next;
    logic [7:0]                 hp_reg, hp_next;
    logic [7:0]                 cur_reg, cur_next;
    logic [8:0]                 lo_reg, lo_next;
    logic [8:0]                 hi_reg, hi_next;
    logic                       done_reg, done_next;
    slt_pkg::entry_t            carry_reg, carry_next;
    logic                       ok_reg, ok_next;
    logic [7:0]                 fp_reg, fp_next;
    logic [31:0]                fk_reg, fk_next;
    logic [31:0]                fv_reg, fv_next;
    logic                       m_valid_reg, m_valid_next;
    logic [slt_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                       m_user_reg, m_user_next;

    logic [9:0]                 mid_sum;
    logic [8:0]                 mid;
    logic                       do_ins;
    logic [slt_pkg::OP_W-1:0]   in_op;
    logic [7:0]                 in_pos;

    assign in_op  = s_axis_tuser;
    assign in_pos = s_axis_tdata[7:0];

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[9:1];

    always_comb
    begin
        if (op_reg == slt_pkg::OP_INS_AT)
        begin
            do_ins = (cur_reg == pos_reg);
        end
        else
        begin
            do_ins = (cur_reg == count_reg + 8'd1)
                  || ((cur_reg <= count_reg) && (key_reg < head.key));
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        pos_next     = pos_reg;
        key_next     = key_reg;
        pay_next     = pay_reg;
        count_next   = count_reg;
        hp_next      = hp_reg;
        cur_next     = cur_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        done_next    = done_reg;
        carry_next   = carry_reg;
        ok_next      = ok_reg;
        fp_next      = fp_reg;
        fk_next      = fk_reg;
        fv_next      = fv_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        emit         = head;
        ring_ctl     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next   = in_op;
                    pos_next  = in_pos;
                    key_next  = s_axis_tdata[39:8];
                    pay_next  = s_axis_tdata[71:40];
                    ok_next   = 1'b0;
                    fp_next   = '0;
                    fk_next   = '0;
                    fv_next   = '0;
                    cur_next  = 8'd1;
                    done_next = 1'b0;
                    lo_next   = 9'd1;
                    hi_next   = {1'b0, count_reg};
                    state_next = S_FINISH;
                    case (in_op)
                        slt_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            ok_next    = 1'b1;
                        end
                        slt_pkg::OP_INS_AT:
                        begin
                            if (count_reg < CAP_W && in_pos != 8'd0
                                && {1'b0, in_pos} <= {1'b0, count_reg} + 9'd1)
                            begin
                                state_next = S_STREAM;
                            end
                        end
                        slt_pkg::OP_INS_SORT:
                        begin
                            if (count_reg < CAP_W)
                            begin
                                state_next = S_STREAM;
                            end
                        end
                        slt_pkg::OP_LIN_FIND:
                        begin
                            state_next = S_STREAM;
                        end
                        slt_pkg::OP_BIN_FIND, slt_pkg::OP_REM_KEY:
                        begin
                            state_next = S_BS;
                        end
                        slt_pkg::OP_REM_AT:
                        begin
                            if (in_pos != 8'd0 && in_pos <= count_reg)
                            begin
                                state_next = S_STREAM;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_STREAM:
            begin
                ring_ctl.fwd = 1'b1;
                case (op_reg)
                    slt_pkg::OP_INS_AT, slt_pkg::OP_INS_SORT:
                    begin
                        if (done_reg)
                        begin
                            emit       = carry_reg;
                            carry_next = head;
                        end
                        else if (do_ins)
                        begin
                            emit.key     = key_reg;
                            emit.payload = pay_reg;
                            carry_next   = head;
                            done_next    = 1'b1;
                            ok_next      = 1'b1;
                            fp_next      = cur_reg;
                            fk_next      = key_reg;
                            fv_next      = pay_reg;
                        end
                    end
                    slt_pkg::OP_LIN_FIND:
                    begin
                        if (!done_reg && cur_reg <= count_reg && head.key == key_reg)
                        begin
                            done_next = 1'b1;
                            ok_next   = 1'b1;
                            fp_next   = cur_reg;
                            fk_next   = head.key;
                            fv_next   = head.payload;
                        end
                    end
                    default:
                    begin
                        // removal: close the gap by taking the next entry
                        if (cur_reg >= pos_reg)
                        begin
                            emit = second;
                        end
                        if (cur_reg == pos_reg)
                        begin
                            ok_next = 1'b1;
                            fp_next = cur_reg;
                            fk_next = head.key;
                            fv_next = head.payload;
                        end
                    end
                endcase
                if (cur_reg == CAP_W)
                begin
                    state_next = S_FINISH;
                    if (ok_next)
                    begin
                        if (op_reg == slt_pkg::OP_INS_AT || op_reg == slt_pkg::OP_INS_SORT)
                        begin
                            count_next = count_reg + 8'd1;
                        end
                        else if (op_reg == slt_pkg::OP_REM_AT
                                 || op_reg == slt_pkg::OP_REM_KEY)
                        begin
                            count_next = count_reg - 8'd1;
                        end
                    end
                end
                else
                begin
                    cur_next = cur_reg + 8'd1;
                end
            end

            S_BS:
            begin
                if (lo_reg > hi_reg || hi_reg == 9'd0)
                begin
                    state_next = S_ALIGN;
                end
                else if ({1'b0, hp_reg} == mid)
                begin
                    if (head.key == key_reg)
                    begin
                        ok_next    = 1'b1;
                        fp_next    = mid[7:0];
                        fk_next    = head.key;
                        fv_next    = head.payload;
                        pos_next   = mid[7:0];
                        state_next = S_ALIGN;
                    end
                    else if (head.key < key_reg)
                    begin
                        lo_next = mid + 9'd1;
                    end
                    else
                    begin
                        hi_next = mid - 9'd1;
                    end
                end
                else if (mid > {1'b0, hp_reg})
                begin
                    ring_ctl.fwd = 1'b1;
                    hp_next      = hp_reg + 8'd1;
                end
                else
                begin
                    ring_ctl.bwd = 1'b1;
                    hp_next      = hp_reg - 8'd1;
                end
            end

            S_ALIGN:
            begin
                if (hp_reg != 8'd1)
                begin
                    ring_ctl.bwd = 1'b1;
                    hp_next      = hp_reg - 8'd1;
                end
                else if (op_reg == slt_pkg::OP_REM_KEY && ok_reg)
                begin
                    cur_next   = 8'd1;
                    state_next = S_STREAM;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = ok_reg;
                    m_data_next  = {6'd0, (count_reg == CAP_W), (count_reg == 8'd0),
                                    count_reg, fv_reg, fk_reg, fp_reg};
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            hp_reg      <= 8'd1;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            hp_reg      <= hp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        pay_reg    <= pay_next;
        cur_reg    <= cur_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        done_reg   <= done_next;
        carry_reg  <= carry_next;
        ok_reg     <= ok_next;
        fp_reg     <= fp_next;
        fk_reg     <= fk_next;
        fv_reg     <= fv_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

// ----- hw/rtl/sequential_list_table.sv -----
// Sorted/unsorted entry list kept in a ring of CAPACITY cells; uses slt_pkg,
// slt_cell and slt_ctrl.
// Clear and rejected operations skip the ring; insert, linear find and
// remove at position make one full ring pass; binary find steers the ring
// to each probe, then back; remove key adds a pass.
// One transaction at a time; the next is taken once the result is registered.
// Reset clears the count and ring alignment; cell contents are not reset.
module sequential_list_table
#(
    parameter int CAPACITY = slt_pkg::CAPACITY
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // position [7:0], key [39:8], payload [71:40]
    input  logic [slt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // operation [2:0]
    input  logic [slt_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // found_position [7:0], found_key [39:8], found_payload [71:40],
    // count [79:72], is_empty [80], is_full [81], zero [87:82]
    output logic [slt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // success [0]
    output logic                            m_axis_tuser
);

    slt_pkg::entry_t    cells [CAPACITY];
    slt_pkg::entry_t    emit;
    slt_pkg::ring_ctl_t ring_ctl;

    slt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .head          (cells[0]),
        .second        (cells[1]),
        .emit          (emit),
        .ring_ctl      (ring_ctl)
    );

    for (genvar j = 0; j < CAPACITY; j++)
    begin : g_cell
        slt_pkg::entry_t next_in;
        slt_pkg::entry_t prev_in;

        if (j == CAPACITY - 1)
        begin : g_tail
            assign next_in = emit;
        end
        else
        begin : g_mid_n
            assign next_in = cells[j+1];
        end

        if (j == 0)
        begin : g_head
            assign prev_in = cells[CAPACITY-1];
        end
        else
        begin : g_mid_p
            assign prev_in = cells[j-1];
        end

        slt_cell u_cell (
            .clk     (clk),
            .ctl     (ring_ctl),
            .next_in (next_in),
            .prev_in (prev_in),
            .entry   (cells[j])
        );
    end

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for sequential_list_table: directed and random list operations.
// Each accepted transaction is checked against a predictor of the list held in the bench.
// Depends on slt_pkg and sequential_list_table.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [slt_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int PHASE_ITEMS  = 80;

    typedef struct {
        logic [slt_pkg::OP_W-1:0]         op;
        logic [slt_pkg::POS_W-1:0]        pos;
        logic signed [slt_pkg::KEY_W-1:0] key;
        logic [slt_pkg::DATA_W-1:0]       payload;
    } list_op_t;

    typedef struct {
        logic                             ok;
        logic [slt_pkg::POS_W-1:0]        pos;
        logic signed [slt_pkg::KEY_W-1:0] key;
        logic [slt_pkg::DATA_W-1:0]       payload;
        logic [7:0]                       cnt;
        logic                             empty;
        logic                             full;
    } list_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [slt_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [slt_pkg::OP_W-1:0]      s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [slt_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                          m_axis_tuser;

    list_op_t     op_queue[$];
    list_result_t pending_results[$];

    logic signed [slt_pkg::KEY_W-1:0] shadow_key [slt_pkg::CAPACITY];
    logic [slt_pkg::DATA_W-1:0]       shadow_pay [slt_pkg::CAPACITY];
    int                               shadow_cnt = 0;

    int mismatch_cnt = 0;
    int cycle_cnt    = 0;
    int items_sent   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    sequential_list_table u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // binary search over positions 1..shadow_cnt; 0 when missed
    function automatic int probe_key(input logic signed [slt_pkg::KEY_W-1:0] k);
        int lo;
        int hi;
        int mid;
        lo = 1;
        hi = shadow_cnt;
        while (lo <= hi && hi >= 1)
        begin
            mid = (lo + hi) / 2;
            if (shadow_key[mid-1] == k)
                return mid;
            if (shadow_key[mid-1] < k)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return 0;
    endfunction

    function automatic list_result_t apply_list_op(input list_op_t r);
        list_result_t res;
        int p;
        int q;
        res = '{default: '0};
        p = r.pos;
        case (r.op)
            slt_pkg::OP_CLEAR:
            begin
                shadow_cnt = 0;
                res.ok = 1'b1;
            end
            slt_pkg::OP_INS_AT, slt_pkg::OP_INS_SORT:
            begin
                if (shadow_cnt < slt_pkg::CAPACITY)
                begin
                    if (r.op == slt_pkg::OP_INS_SORT)
                    begin
                        p = shadow_cnt + 1;
                        for (q = 1; q <= shadow_cnt; q++)
                        begin
                            if (r.key < shadow_key[q-1])
                            begin
                                p = q;
                                break;
                            end
                        end
                    end
                    if (p >= 1 && p <= shadow_cnt + 1)
                    begin
                        for (q = shadow_cnt; q >= p; q--)
                        begin
                            shadow_key[q] = shadow_key[q-1];
                            shadow_pay[q] = shadow_pay[q-1];
                        end
                        shadow_key[p-1] = r.key;
                        shadow_pay[p-1] = r.payload;
                        shadow_cnt++;
                        res.ok = 1'b1;
                        res.pos = p[slt_pkg::POS_W-1:0];
                        res.key = r.key;
                        res.payload = r.payload;
                    end
                end
            end
            slt_pkg::OP_LIN_FIND:
            begin
                for (q = 1; q <= shadow_cnt; q++)
                begin
                    if (shadow_key[q-1] == r.key)
                    begin
                        res.ok = 1'b1;
                        res.pos = q[slt_pkg::POS_W-1:0];
                        res.key = shadow_key[q-1];
                        res.payload = shadow_pay[q-1];
                        break;
                    end
                end
            end
            slt_pkg::OP_BIN_FIND, slt_pkg::OP_REM_KEY, slt_pkg::OP_REM_AT:
            begin
                if (r.op != slt_pkg::OP_REM_AT)
                    p = probe_key(r.key);
                else if (p > shadow_cnt)
                    p = 0;
                if (p != 0)
                begin
                    res.ok = 1'b1;
                    res.pos = p[slt_pkg::POS_W-1:0];
                    res.key = shadow_key[p-1];
                    res.payload = shadow_pay[p-1];
                    if (r.op != slt_pkg::OP_BIN_FIND)
                    begin
                        for (q = p; q < shadow_cnt; q++)
                        begin
                            shadow_key[q-1] = shadow_key[q];
                            shadow_pay[q-1] = shadow_pay[q];
                        end
                        shadow_cnt--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.cnt = shadow_cnt[7:0];
        res.empty = (shadow_cnt == 0);
        res.full = (shadow_cnt == slt_pkg::CAPACITY);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (op_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {op_queue[0].payload, op_queue[0].key, op_queue[0].pos};
                s_axis_tuser  <= op_queue[0].op;
                void'(op_queue.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: results first, since a result never belongs to a transaction taken at that edge
    always @(posedge clk)
    begin
        list_result_t want;
        list_op_t     got_op;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, expected none, got %h",
                             $time, m_axis_tdata);
                    mismatch_cnt++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("success", want.ok, m_axis_tuser);
                    check_field("found_position", want.pos, m_axis_tdata[7:0]);
                    check_field("found_key", want.key, m_axis_tdata[39:8]);
                    check_field("found_payload", want.payload, m_axis_tdata[71:40]);
                    check_field("count", want.cnt, m_axis_tdata[79:72]);
                    check_field("is_empty", want.empty, m_axis_tdata[80]);
                    check_field("is_full", want.full, m_axis_tdata[81]);
                    check_field("pad", 32'd0, m_axis_tdata[87:82]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                got_op.op      = s_axis_tuser;
                got_op.pos     = s_axis_tdata[7:0];
                got_op.key     = s_axis_tdata[39:8];
                got_op.payload = s_axis_tdata[71:40];
                pending_results.push_back(apply_list_op(got_op));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // queue one transaction and wait until the block has taken it
    task automatic send(input logic [slt_pkg::OP_W-1:0] op, input int pos,
                        input logic signed [slt_pkg::KEY_W-1:0] key,
                        input logic [slt_pkg::DATA_W-1:0] pay);
        list_op_t r;
        r.op = op;
        r.pos = pos[slt_pkg::POS_W-1:0];
        r.key = key;
        r.payload = pay;
        op_queue.push_back(r);
        items_sent++;
        do
            @(negedge clk);
        while (op_queue.size() != 0 || s_axis_tvalid);
    endtask

    function automatic logic signed [slt_pkg::KEY_W-1:0] pick_key(input bit narrow);
        logic signed [slt_pkg::KEY_W-1:0] k;
        if (shadow_cnt > 0 && $urandom_range(0, 9) < 6)
            k = shadow_key[$urandom_range(0, shadow_cnt - 1)];
        else if (narrow)
        begin
            k = $urandom_range(0, 15);
            k = k - 8;
        end
        else
            k = $urandom;
        return k;
    endfunction

    function automatic int pick_pos();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(0, 255);
            2: return shadow_cnt + 1 + $urandom_range(0, 1);
            default: return $urandom_range(1, shadow_cnt + 1);
        endcase
    endfunction

    task automatic sorted_run();
        int n;
        bit narrow;
        narrow = $urandom_range(0, 1);
        send(slt_pkg::OP_CLEAR, pick_pos(), $urandom, $urandom);
        n = $urandom_range(1, 24);
        repeat (n)
            send(slt_pkg::OP_INS_SORT, pick_pos(), pick_key(narrow), $urandom);
        n = $urandom_range(4, 12);
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0: send(slt_pkg::OP_BIN_FIND, pick_pos(), pick_key(narrow), $urandom);
                1: send(slt_pkg::OP_LIN_FIND, pick_pos(), pick_key(narrow), $urandom);
                2: send(slt_pkg::OP_REM_KEY, pick_pos(), pick_key(narrow), $urandom);
                default: send(slt_pkg::OP_REM_AT, pick_pos(), pick_key(narrow), $urandom);
            endcase
        end
    endtask

    task automatic mixed_run();
        int w;
        bit narrow;
        logic [slt_pkg::OP_W-1:0] op;
        narrow = $urandom_range(0, 1);
        repeat (20)
        begin
            w = $urandom_range(0, 99);
            if (w < 3)       op = slt_pkg::OP_CLEAR;
            else if (w < 20) op = slt_pkg::OP_INS_AT;
            else if (w < 40) op = slt_pkg::OP_INS_SORT;
            else if (w < 52) op = slt_pkg::OP_LIN_FIND;
            else if (w < 66) op = slt_pkg::OP_BIN_FIND;
            else if (w < 78) op = slt_pkg::OP_REM_AT;
            else if (w < 95) op = slt_pkg::OP_REM_KEY;
            else             op = OP_UNUSED;
            send(op, pick_pos(), pick_key(narrow), $urandom);
        end
    endtask

    task automatic fill_run();
        while (shadow_cnt < slt_pkg::CAPACITY)
            send(slt_pkg::OP_INS_SORT, pick_pos(), pick_key(1'b0), $urandom);
        send(slt_pkg::OP_INS_SORT, 0, $urandom, $urandom);
        send(slt_pkg::OP_INS_AT, 1, $urandom, $urandom);
        send(slt_pkg::OP_INS_AT, slt_pkg::CAPACITY + 1, $urandom, $urandom);
        send(slt_pkg::OP_BIN_FIND, 0, pick_key(1'b0), $urandom);
        send(slt_pkg::OP_LIN_FIND, 0, shadow_key[slt_pkg::CAPACITY-1], $urandom);
        send(slt_pkg::OP_REM_AT, slt_pkg::CAPACITY + 1, 0, 0);
        send(slt_pkg::OP_REM_AT, slt_pkg::CAPACITY, 0, 0);
        send(slt_pkg::OP_INS_AT, slt_pkg::CAPACITY, $urandom, $urandom);
        send(slt_pkg::OP_REM_KEY, 0, pick_key(1'b0), $urandom);
        send(slt_pkg::OP_REM_AT, 1, 0, 0);
    endtask

    initial
    begin
        int phase_start;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty list, bad positions, key extremes, equal keys, unused code
        send(slt_pkg::OP_REM_AT, 1, 0, 0);
        send(slt_pkg::OP_BIN_FIND, 0, 0, 0);
        send(slt_pkg::OP_LIN_FIND, 0, 0, 0);
        send(slt_pkg::OP_REM_KEY, 0, 0, 0);
        send(slt_pkg::OP_INS_AT, 0, 5, 32'h1);
        send(slt_pkg::OP_INS_AT, 2, 5, 32'h1);
        send(slt_pkg::OP_INS_AT, 1, 32'sh8000_0000, 32'h0);
        send(slt_pkg::OP_INS_AT, 2, 32'sh7fff_ffff, 32'hffff_ffff);
        send(slt_pkg::OP_INS_AT, 2, 0, 32'ha5a5_a5a5);
        send(slt_pkg::OP_INS_SORT, 0, -1, 32'h5a5a_5a5a);
        send(slt_pkg::OP_INS_SORT, 255, 0, 32'h1234_5678);
        send(OP_UNUSED, 255, -1, 32'hffff_ffff);
        send(slt_pkg::OP_LIN_FIND, 0, 32'sh7fff_ffff, 0);
        send(slt_pkg::OP_BIN_FIND, 0, 32'sh8000_0000, 0);
        send(slt_pkg::OP_BIN_FIND, 0, 0, 0);
        send(slt_pkg::OP_BIN_FIND, 0, 77, 0);
        send(slt_pkg::OP_REM_KEY, 0, 77, 0);
        send(slt_pkg::OP_REM_KEY, 0, 0, 0);
        send(slt_pkg::OP_INS_AT, 1, 32'sh7fff_ffff, 32'h0);
        send(slt_pkg::OP_BIN_FIND, 0, 32'sh8000_0000, 0);
        send(slt_pkg::OP_REM_AT, 6, 0, 0);
        send(slt_pkg::OP_REM_AT, 255, 0, 0);
        send(slt_pkg::OP_REM_AT, 1, 0, 0);
        send(slt_pkg::OP_CLEAR, 0, 0, 0);
        send(slt_pkg::OP_CLEAR, 255, -1, 32'hffff_ffff);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            phase_start = items_sent;
            if (phase == 0 || phase == 3)
                fill_run();
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 1) != 0)
                    sorted_run();
                else
                    mixed_run();
            end
        end

        while (op_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(negedge clk);
        repeat (2 * slt_pkg::CAPACITY + 20) @(negedge clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
